/* src/hwo_pkg.sv */
package hwo_pkg;

	localparam int SRC_ROWS  = 256;
	localparam int SRC_COLS  = 512;
	localparam int DEST_ROWS = 1024;
	localparam int DEST_COLS = 1024;

	localparam int PIX_W  = 10;
	localparam int CH_W   = 8;
	localparam int RGB_W  = 3 * CH_W;
	localparam int COEF_W = 32;
	localparam int IDX_W  = 3;

	localparam int FRAC   = 16;
	localparam int CRD_W  = 13;
	localparam int PROD_W = COEF_W + CRD_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int MAG_W  = SUM_W - 1;

	localparam int RB      = $clog2(SRC_ROWS);
	localparam int CB      = $clog2(SRC_COLS);
	localparam int QB      = ((RB > CB) ? RB : CB) + FRAC;
	localparam int SH      = QB - FRAC;
	localparam int BANK_AW = RB + CB - 2;
	localparam int WT_W    = 2 * FRAC + 1;
	localparam int PW      = WT_W + CH_W;
	localparam int ACC_W   = PW + 2;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [CH_W-1:0] WHITE_LEVEL = CH_W'(240);
	localparam logic [CH_W-1:0] DARK_LEVEL  = CH_W'(15);

	localparam logic signed [SUM_W-1:0] DEN_ONE = SUM_W'(64'sd1 <<< 21);

	localparam logic [QB-1:0] HALF = QB'(1 << (FRAC - 1));
	localparam logic [QB-1:0] XLIM = QB'((SRC_COLS - 1) * (1 << FRAC));
	localparam logic [QB-1:0] YTOP = QB'(SRC_ROWS * (1 << FRAC) - (1 << (FRAC - 1)));

	localparam logic signed [COEF_W-1:0] RST_XX = 32'sd198810;
	localparam logic signed [COEF_W-1:0] RST_XY = 32'sd1538051;
	localparam logic signed [COEF_W-1:0] RST_XO = -32'sd246253250;
	localparam logic signed [COEF_W-1:0] RST_YX = -32'sd407057;
	localparam logic signed [COEF_W-1:0] RST_YY = 32'sd134113;
	localparam logic signed [COEF_W-1:0] RST_YO = 32'sd264408924;
	localparam logic signed [COEF_W-1:0] RST_WX = 32'sd315;
	localparam logic signed [COEF_W-1:0] RST_WY = -32'sd3251;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_PROC = 1'b1
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_XX, REG_XY, REG_XO, REG_YX, REG_YY, REG_YO, REG_WX, REG_WY
	} reg_idx_t;

	typedef struct packed {
		logic             cmd;
		logic             in_rng;
		logic [PIX_W-1:0] row;
		logic [PIX_W-1:0] col;
		logic [RGB_W-1:0] rgb;
	} item_t;

	typedef struct packed {
		logic             off;
		logic [MAG_W-1:0] nx;
		logic [MAG_W-1:0] ny;
		logic [MAG_W-1:0] w;
	} num_t;

	typedef struct packed {
		item_t item;
		num_t  num;
	} qent_t;

	typedef struct packed {
		item_t         item;
		logic          off;
		logic [QB-1:0] qx;
		logic [QB-1:0] qy;
	} div_res_t;

endpackage

/* src/hwo_front.sv */
module hwo_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [hwo_pkg::PIX_W-1:0]   pix_row,
	input  logic [hwo_pkg::PIX_W-1:0]   pix_col,
	input  logic [hwo_pkg::CH_W-1:0]    in_red,
	input  logic [hwo_pkg::CH_W-1:0]    in_green,
	input  logic [hwo_pkg::CH_W-1:0]    in_blue,
	input  logic                        cfg_we,
	input  logic [hwo_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [hwo_pkg::COEF_W-1:0]  cfg_data,
	input  logic                        q_full,
	output logic                        push,
	output hwo_pkg::qent_t              push_data
);
	import hwo_pkg::*;

	logic signed [COEF_W-1:0] xx_q, xy_q, xo_q, yx_q, yy_q, yo_q, wx_q, wy_q;

	logic en;
	logic signed [CRD_W-1:0] x2, y2;
	logic rng;
	logic [RGB_W-1:0] rgb;

	logic v_s1, v_s2, v_s3;
	item_t it_s1, it_s2, it_s3;
	logic signed [PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1, pwx_s1, pwy_s1;
	logic signed [SUM_W-1:0] nx_s2, ny_s2, w_s2;
	logic [MAG_W-1:0] nx_s3, ny_s3, w_s3;
	logic off_s3;
	logic signed [SUM_W-1:0] nxn, nyn, wn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_q <= RST_XX;
			xy_q <= RST_XY;
			xo_q <= RST_XO;
			yx_q <= RST_YX;
			yy_q <= RST_YY;
			yo_q <= RST_YO;
			wx_q <= RST_WX;
			wy_q <= RST_WY;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_XX: xx_q <= cfg_data;
				REG_XY: xy_q <= cfg_data;
				REG_XO: xo_q <= cfg_data;
				REG_YX: yx_q <= cfg_data;
				REG_YY: yy_q <= cfg_data;
				REG_YO: yo_q <= cfg_data;
				REG_WX: wx_q <= cfg_data;
				REG_WY: wy_q <= cfg_data;
			endcase
		end
	end

	assign en       = !(v_s3 && q_full);
	assign in_stall = !en;
	assign push     = v_s3 && !q_full;

	// pixel centre in half units, y counted up from the bottom edge
	assign x2 = signed'({2'b00, pix_col, 1'b1});
	assign y2 = signed'(CRD_W'(2 * DEST_ROWS - 1)) - signed'({2'b00, pix_row, 1'b0});

	always_comb begin
		if (cmd == CMD_PROC) begin
			rng = (pix_row < DEST_ROWS) && (pix_col < DEST_COLS);
		end else begin
			rng = (pix_row < SRC_ROWS) && (pix_col < SRC_COLS);
		end
		if (cmd == CMD_LOAD && in_red > WHITE_LEVEL && in_green > WHITE_LEVEL
				&& in_blue > WHITE_LEVEL) begin
			rgb = '1;
		end else begin
			rgb = {in_red, in_green, in_blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign nxn = w_s2[SUM_W-1] ? -nx_s2 : nx_s2;
	assign nyn = w_s2[SUM_W-1] ? -ny_s2 : ny_s2;
	assign wn  = w_s2[SUM_W-1] ? -w_s2 : w_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1.cmd    <= cmd;
			it_s1.in_rng <= rng;
			it_s1.row    <= pix_row;
			it_s1.col    <= pix_col;
			it_s1.rgb    <= rgb;
			pxx_s1 <= xx_q * x2;
			pxy_s1 <= xy_q * y2;
			pyx_s1 <= yx_q * x2;
			pyy_s1 <= yy_q * y2;
			pwx_s1 <= wx_q * x2;
			pwy_s1 <= wy_q * y2;

			it_s2 <= it_s1;
			nx_s2 <= SUM_W'(pxx_s1) + SUM_W'(pxy_s1) + (SUM_W'(xo_q) <<< 1);
			ny_s2 <= SUM_W'(pyx_s1) + SUM_W'(pyy_s1) + (SUM_W'(yo_q) <<< 1);
			w_s2  <= SUM_W'(pwx_s1) + SUM_W'(pwy_s1) + DEN_ONE;

			// sign folded into the numerators; negative quotient is off-source
			it_s3  <= it_s2;
			nx_s3  <= nxn[MAG_W-1:0];
			ny_s3  <= nyn[MAG_W-1:0];
			w_s3   <= wn[MAG_W-1:0];
			off_s3 <= (w_s2 == '0) || nxn[SUM_W-1] || nyn[SUM_W-1];
		end
	end

	assign push_data.item    = it_s3;
	assign push_data.num.off = off_s3;
	assign push_data.num.nx  = nx_s3;
	assign push_data.num.ny  = ny_s3;
	assign push_data.num.w   = w_s3;

endmodule

/* src/hwo_fifo.sv */
module hwo_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hwo_pkg::qent_t din,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output hwo_pkg::qent_t dout
);
	import hwo_pkg::*;

	qent_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0] cnt_q;

	assign full      = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

/* src/hwo_div.sv */
module hwo_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  hwo_pkg::qent_t    din,
	output logic              pop,
	output logic              out_valid,
	output hwo_pkg::div_res_t dout
);
	import hwo_pkg::*;

	// one quotient bit per stage for both coordinates, shared denominator
	logic          v_s   [QB+1];
	item_t         it_s  [QB+1];
	logic          off_s [QB+1];
	logic [QB-1:0] qx_s  [QB+1];
	logic [QB-1:0] qy_s  [QB+1];
	logic [MAG_W-1:0] w_s  [QB];
	logic [MAG_W-1:0] rx_s [QB];
	logic [MAG_W-1:0] ry_s [QB];
	logic [QB-1:0]    dx_s [QB];
	logic [QB-1:0]    dy_s [QB];

	logic ovf;

	assign pop = en && in_valid;

	// quotient would not fit: surely outside the source
	assign ovf = ({SH'(0), din.num.nx} >= {din.num.w, SH'(0)})
		|| ({SH'(0), din.num.ny} >= {din.num.w, SH'(0)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s[0]  <= din.item;
			off_s[0] <= din.num.off || ovf;
			w_s[0]   <= din.num.w;
			rx_s[0]  <= MAG_W'(din.num.nx >> SH);
			ry_s[0]  <= MAG_W'(din.num.ny >> SH);
			dx_s[0]  <= {din.num.nx[SH-1:0], FRAC'(0)};
			dy_s[0]  <= {din.num.ny[SH-1:0], FRAC'(0)};
			qx_s[0]  <= '0;
			qy_s[0]  <= '0;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [MAG_W:0] tx, ty;
		logic gx, gy;

		assign tx = {rx_s[k-1], dx_s[k-1][QB-1]};
		assign ty = {ry_s[k-1], dy_s[k-1][QB-1]};
		assign gx = (tx >= {1'b0, w_s[k-1]});
		assign gy = (ty >= {1'b0, w_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k]  <= it_s[k-1];
				off_s[k] <= off_s[k-1];
				qx_s[k]  <= {qx_s[k-1][QB-2:0], gx};
				qy_s[k]  <= {qy_s[k-1][QB-2:0], gy};
			end
		end

		if (k < QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					w_s[k]  <= w_s[k-1];
					rx_s[k] <= gx ? MAG_W'(tx - {1'b0, w_s[k-1]}) : tx[MAG_W-1:0];
					ry_s[k] <= gy ? MAG_W'(ty - {1'b0, w_s[k-1]}) : ty[MAG_W-1:0];
					dx_s[k] <= {dx_s[k-1][QB-2:0], 1'b0};
					dy_s[k] <= {dy_s[k-1][QB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[QB];
	assign dout.item = it_s[QB];
	assign dout.off  = off_s[QB];
	assign dout.qx   = qx_s[QB];
	assign dout.qy   = qy_s[QB];

endmodule

/* src/hwo_interp.sv */
module hwo_interp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  hwo_pkg::div_res_t        din,
	output logic                     out_valid,
	output logic [hwo_pkg::CH_W-1:0] out_red,
	output logic [hwo_pkg::CH_W-1:0] out_green,
	output logic [hwo_pkg::CH_W-1:0] out_blue,
	output logic                     overlaid
);
	import hwo_pkg::*;

	logic x_ok, y_ok, hit;
	logic [QB-1:0] sc, sr;

	logic v_s1, v_s2, v_s3, v_s4;
	item_t it_s1, it_s2, it_s3;
	logic hit_s1, hit_s2, hit_s3;
	logic [RB-1:0] pr_s1;
	logic [CB-1:0] pc_s1;
	logic [FRAC-1:0] dr_s1, dc_s1;

	logic [RGB_W-1:0] rd_s2 [4];
	logic r0_s2, c0_s2;
	logic [WT_W-1:0] w00_s2, w01_s2, w10_s2, w11_s2;
	logic [FRAC:0] fr, fc, er, ec;

	logic [RGB_W-1:0] p00, p01, p10, p11;
	logic [PW-1:0] m00_s3 [3];
	logic [PW-1:0] m01_s3 [3];
	logic [PW-1:0] m10_s3 [3];
	logic [PW-1:0] m11_s3 [3];

	logic [CH_W-1:0] val [3];
	logic dark;
	logic [CH_W-1:0] red_s4, green_s4, blue_s4;
	logic ovl_s4;

	assign x_ok = (din.qx >= HALF) && ((din.qx - HALF) < XLIM);
	assign y_ok = (din.qy > HALF) && (din.qy <= YTOP);
	assign sc   = din.qx - HALF;
	assign sr   = YTOP - din.qy;
	assign hit  = (din.item.cmd == CMD_PROC) && din.item.in_rng && !din.off && x_ok && y_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && (it_s3.cmd == CMD_PROC);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= din.item;
			hit_s1 <= hit;
			pr_s1  <= sr[FRAC+RB-1:FRAC];
			pc_s1  <= sc[FRAC+CB-1:FRAC];
			dr_s1  <= sr[FRAC-1:0];
			dc_s1  <= sc[FRAC-1:0];
		end
	end

	// four banks by row and column parity: a 2x2 window hits each once
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic BA = 1'((b >> 1) & 1);
		localparam logic BC = 1'(b & 1);
		logic [RGB_W-1:0] mem [2**BANK_AW];
		logic [RB-2:0] rh;
		logic [CB-2:0] ch;
		logic wsel;

		assign rh   = pr_s1[RB-1:1] + (RB-1)'(pr_s1[0] & ~BA);
		assign ch   = pc_s1[CB-1:1] + (CB-1)'(pc_s1[0] & ~BC);
		assign wsel = v_s1 && (it_s1.cmd == CMD_LOAD) && it_s1.in_rng
			&& (it_s1.row[0] == BA) && (it_s1.col[0] == BC);

		always_ff @(posedge clk) begin
			if (en) begin
				if (wsel) begin
					mem[{it_s1.row[RB-1:1], it_s1.col[CB-1:1]}] <= it_s1.rgb;
				end
				rd_s2[b] <= mem[{rh, ch}];
			end
		end
	end

	assign er = {1'b0, dr_s1};
	assign ec = {1'b0, dc_s1};
	assign fr = (FRAC+1)'(1 << FRAC) - er;
	assign fc = (FRAC+1)'(1 << FRAC) - ec;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2  <= it_s1;
			hit_s2 <= hit_s1;
			r0_s2  <= pr_s1[0];
			c0_s2  <= pc_s1[0];
			w00_s2 <= fr * fc;
			w01_s2 <= fr * ec;
			w10_s2 <= er * fc;
			w11_s2 <= er * ec;
		end
	end

	assign p00 = rd_s2[{r0_s2, c0_s2}];
	assign p01 = rd_s2[{r0_s2, ~c0_s2}];
	assign p10 = rd_s2[{~r0_s2, c0_s2}];
	assign p11 = rd_s2[{~r0_s2, ~c0_s2}];

	for (genvar k = 0; k < 3; k++) begin : g_chan
		logic [ACC_W-1:0] acc;

		always_ff @(posedge clk) begin
			if (en) begin
				m00_s3[k] <= p00[RGB_W-1-CH_W*k -: CH_W] * w00_s2;
				m01_s3[k] <= p01[RGB_W-1-CH_W*k -: CH_W] * w01_s2;
				m10_s3[k] <= p10[RGB_W-1-CH_W*k -: CH_W] * w10_s2;
				m11_s3[k] <= p11[RGB_W-1-CH_W*k -: CH_W] * w11_s2;
			end
		end

		assign acc = ACC_W'(m00_s3[k]) + ACC_W'(m01_s3[k]) + ACC_W'(m10_s3[k])
			+ ACC_W'(m11_s3[k]);
		assign val[k] = acc[2*FRAC +: CH_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3  <= it_s2;
			hit_s3 <= hit_s2;
		end
	end

	assign dark = (val[0] < DARK_LEVEL) && (val[1] < DARK_LEVEL) && (val[2] < DARK_LEVEL);

	always_ff @(posedge clk) begin
		if (en) begin
			if (hit_s3 && !dark) begin
				red_s4   <= val[0];
				green_s4 <= val[1];
				blue_s4  <= val[2];
				ovl_s4   <= 1'b1;
			end else begin
				red_s4   <= it_s3.rgb[RGB_W-1 -: CH_W];
				green_s4 <= it_s3.rgb[RGB_W-1-CH_W -: CH_W];
				blue_s4  <= it_s3.rgb[CH_W-1:0];
				ovl_s4   <= 1'b0;
			end
		end
	end

	assign out_valid = v_s4;
	assign out_red   = red_s4;
	assign out_green = green_s4;
	assign out_blue  = blue_s4;
	assign overlaid  = ovl_s4;

endmodule

/* src/homography_warp_overlay_top.sv */
// Path from an accepted beat to its result: 3 front stages, the queue, one divider stage
//   per quotient bit and 4 interpolation stages.
// Throughput: one beat per cycle unless out_stall holds the result; the bit-serial divider
//   pipeline and the four parity-banked source memories each take a new beat every cycle.
// Reset clears the coefficients to their defaults and empties all pipelines and the
//   queue; the source memory is not cleared and holds nothing until loaded.
module homography_warp_overlay_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [hwo_pkg::PIX_W-1:0]   pix_row,
	input  logic [hwo_pkg::PIX_W-1:0]   pix_col,
	input  logic [hwo_pkg::CH_W-1:0]    in_red,
	input  logic [hwo_pkg::CH_W-1:0]    in_green,
	input  logic [hwo_pkg::CH_W-1:0]    in_blue,
	input  logic                        cfg_we,
	input  logic [hwo_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [hwo_pkg::COEF_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hwo_pkg::CH_W-1:0]    out_red,
	output logic [hwo_pkg::CH_W-1:0]    out_green,
	output logic [hwo_pkg::CH_W-1:0]    out_blue,
	output logic                        overlaid
);
	import hwo_pkg::*;

	logic q_full, push, pop, q_ne, div_v, en_b;
	qent_t push_data, q_data;
	div_res_t div_data;

	assign en_b = !(out_valid && out_stall);

	hwo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.pix_row   (pix_row),
		.pix_col   (pix_col),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	hwo_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_ne),
		.dout      (q_data)
	);

	hwo_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (q_ne),
		.din       (q_data),
		.pop       (pop),
		.out_valid (div_v),
		.dout      (div_data)
	);

	hwo_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (div_v),
		.din       (div_data),
		.out_valid (out_valid),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.overlaid  (overlaid)
	);

endmodule

/* src/hwo_checker.sv */
module hwo_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [hwo_pkg::CH_W-1:0]  out_red,
	input logic [hwo_pkg::CH_W-1:0]  out_green,
	input logic [hwo_pkg::CH_W-1:0]  out_blue,
	input logic                      overlaid
);
	import hwo_pkg::*;

	// a held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(overlaid))
		else $error("stalled result beat changed");

	// a warped pixel is never dark
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overlaid |-> !(out_red < DARK_LEVEL && out_green < DARK_LEVEL
			&& out_blue < DARK_LEVEL))
		else $error("dark sample marked as overlaid");

	// nothing leaves the pipeline straight after reset
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result beat right after reset");

endmodule

bind homography_warp_overlay_top hwo_checker u_chk (.*);

/* dv/homography_warp_overlay_top_test.sv */
module homography_warp_overlay_top_test;
	import hwo_pkg::*;

	localparam int PATCH_R = 8;
	localparam int PATCH_C = 24;

	typedef struct {
		cmd_t            op;
		logic [PIX_W-1:0] row;
		logic [PIX_W-1:0] col;
		logic [CH_W-1:0]  r, g, b;
	} beat_t;

	typedef struct {
		logic [CH_W-1:0] r, g, b;
		logic            ov;
		logic            known;
	} blend_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic cmd = 0;
	logic [PIX_W-1:0] pix_row = 0, pix_col = 0;
	logic [CH_W-1:0] in_red = 0, in_green = 0, in_blue = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_idx = 0;
	logic [COEF_W-1:0] cfg_data = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [CH_W-1:0] out_red, out_green, out_blue;
	logic overlaid;

	beat_t  pending[$];
	blend_t blend_exp[$];
	beat_t  cur;
	longint coef[8];
	logic [RGB_W-1:0] src_img [SRC_ROWS*SRC_COLS];
	bit src_wr [SRC_ROWS*SRC_COLS];
	int errors = 0;
	int snd_idle = 0, rcv_idle = 0;
	int hold_seq = 0, hold_seen = 0, hold_cnt = 0;

	homography_warp_overlay_top u_dut (.*);

	always #1 clk = ~clk;

	function automatic longint floor_div(longint n, longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic logic [7:0] lerp(logic [7:0] a, logic [7:0] b2, logic [7:0] c,
			logic [7:0] d, longint w00, longint w01, longint w10, longint w11);
		longint acc;
		acc = a * w00 + b2 * w01 + c * w10 + d * w11;
		return acc[39:32];
	endfunction

	task automatic predict_beat(beat_t bt);
		blend_t e;
		longint x2, y2, nx, ny, w, sc, sr, pr, pc, dr, dc;
		longint w00, w01, w10, w11;
		logic [RGB_W-1:0] p00, p01, p10, p11;
		logic [7:0] v0, v1, v2;
		logic known;
		if (bt.op == CMD_LOAD) begin
			if (bt.row < SRC_ROWS && bt.col < SRC_COLS) begin
				if (bt.r > WHITE_LEVEL && bt.g > WHITE_LEVEL && bt.b > WHITE_LEVEL)
					src_img[bt.row*SRC_COLS + bt.col] = '1;
				else
					src_img[bt.row*SRC_COLS + bt.col] = {bt.r, bt.g, bt.b};
				src_wr[bt.row*SRC_COLS + bt.col] = 1'b1;
			end
			return;
		end
		e = '{bt.r, bt.g, bt.b, 1'b0, 1'b1};
		x2 = 2 * bt.col + 1;
		y2 = 2 * DEST_ROWS - 2 * bt.row - 1;
		nx = coef[REG_XX] * x2 + coef[REG_XY] * y2 + 2 * coef[REG_XO];
		ny = coef[REG_YX] * x2 + coef[REG_YY] * y2 + 2 * coef[REG_YO];
		w = coef[REG_WX] * x2 + coef[REG_WY] * y2 + (64'sd1 <<< 21);
		if (w != 0) begin
			if (w < 0) begin
				w = -w; nx = -nx; ny = -ny;
			end
			sc = floor_div(nx * 65536, w) - 32768;
			sr = SRC_ROWS * 65536 - floor_div(ny * 65536, w) - 32768;
			if (sc >= 0 && sr >= 0 && (sr >>> 16) <= SRC_ROWS - 2
					&& (sc >>> 16) <= SRC_COLS - 2) begin
				pr = sr >>> 16;
				pc = sc >>> 16;
				dr = sr & 65535;
				dc = sc & 65535;
				w00 = (65536 - dr) * (65536 - dc);
				w01 = (65536 - dr) * dc;
				w10 = dr * (65536 - dc);
				w11 = dr * dc;
				known = src_wr[pr*SRC_COLS + pc] && src_wr[pr*SRC_COLS + pc + 1]
					&& src_wr[(pr+1)*SRC_COLS + pc] && src_wr[(pr+1)*SRC_COLS + pc + 1];
				p00 = src_img[pr*SRC_COLS + pc];
				p01 = src_img[pr*SRC_COLS + pc + 1];
				p10 = src_img[(pr+1)*SRC_COLS + pc];
				p11 = src_img[(pr+1)*SRC_COLS + pc + 1];
				v0 = lerp(p00[23:16], p01[23:16], p10[23:16], p11[23:16], w00, w01, w10, w11);
				v1 = lerp(p00[15:8], p01[15:8], p10[15:8], p11[15:8], w00, w01, w10, w11);
				v2 = lerp(p00[7:0], p01[7:0], p10[7:0], p11[7:0], w00, w01, w10, w11);
				// window touches a pixel never loaded: result not defined
				if (!known)
					e.known = 1'b0;
				else if (!(v0 < DARK_LEVEL && v1 < DARK_LEVEL && v2 < DARK_LEVEL))
					e = '{v0, v1, v2, 1'b1, 1'b1};
			end
		end
		blend_exp.push_back(e);
	endtask

	// driver: beat accepted on valid && !stall, then the next one is offered
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				predict_beat(cur);
			if (pending.size() > 0 && $urandom_range(99) >= snd_idle) begin
				cur = pending.pop_front();
				in_valid <= 1;
				cmd <= cur.op;
				pix_row <= cur.row;
				pix_col <= cur.col;
				in_red <= cur.r;
				in_green <= cur.g;
				in_blue <= cur.b;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_cnt <= 400;
			out_stall <= 1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		blend_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (blend_exp.size() == 0) begin
				flag_mismatch("output beat count", 1, 0);
			end else begin
				e = blend_exp.pop_front();
				if (e.known) begin
					if (out_red !== e.r) flag_mismatch("out_red", out_red, e.r);
					if (out_green !== e.g) flag_mismatch("out_green", out_green, e.g);
					if (out_blue !== e.b) flag_mismatch("out_blue", out_blue, e.b);
					if (overlaid !== e.ov) flag_mismatch("overlaid", overlaid, e.ov);
				end
			end
		end
	end

	function automatic beat_t mk_beat(cmd_t op, int row, int col, int r, int g, int b);
		beat_t bt;
		bt.op = op;
		bt.row = PIX_W'(row);
		bt.col = PIX_W'(col);
		bt.r = CH_W'(r);
		bt.g = CH_W'(g);
		bt.b = CH_W'(b);
		return bt;
	endfunction

	function automatic beat_t rand_beat();
		int r, g, b, row, col;
		if ($urandom_range(3) == 0) begin
			r = $urandom_range(255, 241); g = $urandom_range(255, 241);
			b = $urandom_range(255, 241);
		end else begin
			r = $urandom_range(255); g = $urandom_range(255); b = $urandom_range(255);
		end
		if ($urandom_range(3) == 0) begin
			row = $urandom_range(1023); col = $urandom_range(1023);
			if ($urandom_range(3) != 0) begin
				row = row % PATCH_R; col = col % PATCH_C;
			end
			return mk_beat(CMD_LOAD, row, col, r, g, b);
		end
		return mk_beat(CMD_PROC, $urandom_range(1023), $urandom_range(1023), r, g, b);
	endfunction

	task automatic drain();
		while (pending.size() > 0 || in_valid || blend_exp.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_coefs(longint c[8]);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1;
			cfg_idx <= reg_idx_t'(i);
			cfg_data <= c[i][31:0];
			coef[i] = longint'(signed'(c[i][31:0]));
		end
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic run_beats(int n);
		for (int i = 0; i < n; i++)
			pending.push_back(rand_beat());
		drain();
	endtask

	initial begin
		longint c[8];
		coef = '{198810, 1538051, -246253250, -407057, 134113, 264408924, 315, -3251};
		snd_idle = 37; rcv_idle = 83;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		// small patch in the top left corner, its top left 4x8 block dark
		for (int rr = 0; rr < PATCH_R; rr++)
			for (int cc = 0; cc < PATCH_C; cc++)
				if (rr < 4 && cc < 8)
					pending.push_back(mk_beat(CMD_LOAD, rr, cc, $urandom_range(14),
						$urandom_range(14), $urandom_range(14)));
				else if ($urandom_range(7) == 0)
					pending.push_back(mk_beat(CMD_LOAD, rr, cc, $urandom_range(255, 241),
						$urandom_range(255, 230), 255));
				else
					pending.push_back(mk_beat(CMD_LOAD, rr, cc, $urandom_range(255),
						$urandom_range(255), $urandom_range(255)));
		drain();

		run_beats(40);

		// whole destination squeezed onto the loaded patch
		c = '{22528, 0, 524288, 0, 6144, 261619712, 0, 0};
		set_coefs(c);
		pending.push_back(mk_beat(CMD_PROC, 0, 0, 0, 0, 0));
		pending.push_back(mk_beat(CMD_PROC, 1023, 1023, 255, 255, 255));
		pending.push_back(mk_beat(CMD_PROC, 0, 1023, 255, 0, 255));
		pending.push_back(mk_beat(CMD_PROC, 1023, 0, 0, 255, 0));
		pending.push_back(mk_beat(CMD_PROC, 1000, 20, 7, 8, 9));
		pending.push_back(mk_beat(CMD_PROC, 100, 100, 1, 2, 3));
		pending.push_back(mk_beat(CMD_LOAD, 256, 0, 1, 2, 3));
		pending.push_back(mk_beat(CMD_LOAD, 0, 512, 1, 2, 3));
		pending.push_back(mk_beat(CMD_LOAD, 1023, 1023, 1, 2, 3));
		pending.push_back(mk_beat(CMD_LOAD, 3, 10, 241, 241, 241));
		pending.push_back(mk_beat(CMD_LOAD, 3, 11, 240, 255, 255));
		pending.push_back(mk_beat(CMD_LOAD, 4, 10, 255, 255, 240));
		pending.push_back(mk_beat(CMD_LOAD, 7, 23, 255, 255, 255));
		pending.push_back(mk_beat(CMD_PROC, 512, 465, 10, 20, 30));
		pending.push_back(mk_beat(CMD_PROC, 512, 470, 10, 20, 30));
		pending.push_back(mk_beat(CMD_PROC, 0, 1022, 5, 5, 5));
		pending.push_back(mk_beat(CMD_PROC, 1, 1021, 5, 5, 5));
		run_beats(80);

		snd_idle = 83; rcv_idle = 37;
		c = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		set_coefs(c);
		run_beats(30);
		c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
		set_coefs(c);
		run_beats(30);

		// denominator through zero at col 0 and negative beyond it
		c = '{-(1 << 19), 0, 0, 0, -(1 << 18), 0, -(1 << 21), 0};
		set_coefs(c);
		pending.push_back(mk_beat(CMD_PROC, 0, 0, 9, 9, 9));
		pending.push_back(mk_beat(CMD_PROC, 500, 0, 9, 9, 9));
		run_beats(40);

		snd_idle = 0; rcv_idle = 0;
		for (int k = 0; k < 3; k++) begin
			c[REG_XX] = 22528 + longint'($urandom_range(2048)) - 1024;
			c[REG_XY] = longint'($urandom_range(2048)) - 1024;
			c[REG_XO] = 524288 + longint'($urandom_range(1 << 20)) - (1 << 19);
			c[REG_YX] = longint'($urandom_range(2048)) - 1024;
			c[REG_YY] = 6144 + longint'($urandom_range(1024)) - 512;
			c[REG_YO] = 261619712 + longint'($urandom_range(1 << 20)) - (1 << 19);
			c[REG_WX] = longint'($urandom_range(16)) - 8;
			c[REG_WY] = longint'($urandom_range(16)) - 8;
			set_coefs(c);
			if (k == 1)
				hold_seq++;
			run_beats(90);
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
